// File: rtl/efc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the byte-wise CRC-32 function of the envelope frame checker.
// Used by every module of the block; depends on nothing else.
package efc_pkg;

  localparam int unsigned CountWidth = 34;

  typedef logic [CountWidth-1:0] count_t;

  localparam count_t COUNT_MAX = '1;
  localparam count_t HDR_BYTES = count_t'(12);
  localparam count_t TRAILER_BYTES = count_t'(4);
  localparam count_t POS_MAGIC = count_t'(3);
  localparam count_t POS_VERSION = count_t'(7);
  localparam count_t POS_LENGTH = count_t'(11);

  localparam logic [31:0] CRC_POLY = 32'hEDB88320;
  localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;
  localparam logic [31:0] CRC_XOROUT = 32'hFFFFFFFF;

  localparam logic [31:0] MAGIC_RESET = 32'h5A424D44;
  localparam logic [31:0] VER_MIN_RESET = 32'd1;
  localparam logic [31:0] VER_MAX_RESET = 32'd2;

  typedef enum logic [1:0] {
    REG_MAGIC   = 2'd0,
    REG_VER_MIN = 2'd1,
    REG_VER_MAX = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_TRUNC   = 3'd1,
    ST_MAGIC   = 3'd2,
    ST_VERSION = 3'd3,
    ST_SIZE    = 3'd4,
    ST_CRC     = 3'd5
  } status_t;

  typedef struct packed {
    logic [31:0] magic;
    logic [31:0] ver_min;
    logic [31:0] ver_max;
  } cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_final;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        payload_valid;
    logic        frame_done;
    status_t     frame_status;
    logic [31:0] version_seen;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] crc;
    crc = crc_in ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      crc = crc[0] ? (CRC_POLY ^ (crc >> 1)) : (crc >> 1);
    end
    return crc;
  endfunction

endpackage

// File: rtl/envelope_frame_checker.sv
`timescale 1ns / 1ps
// Envelope frame checker: header, payload pass-through, CRC-32 trailer and final status.
// Each input byte passes the input register, then the result register; one byte per cycle while result_stall is low.
// The byte-wise CRC update is combinational between the input and result registers.
// Reset is synchronous: it clears the pipeline, the frame state and restores the registers.
// Depends on efc_pkg, efc_in_reg, efc_core and efc_out_reg.
module envelope_frame_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  output logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_final,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [7:0]  payload_byte,
  output logic        payload_valid,
  output logic        frame_done,
  output logic [2:0]  frame_status,
  output logic [31:0] version_seen,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import efc_pkg::*;

  cfg_t     cfg;
  in_item_t item;
  result_t  result;
  logic     item_valid;
  logic     out_ready;
  logic     step;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.magic <= MAGIC_RESET;
      cfg.ver_min <= VER_MIN_RESET;
      cfg.ver_max <= VER_MAX_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAGIC:   cfg.magic <= cfg_data;
        REG_VER_MIN: cfg.ver_min <= cfg_data;
        REG_VER_MAX: cfg.ver_max <= cfg_data;
        default:     ;
      endcase
    end
  end

  efc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .data_valid (data_valid),
    .data_stall (data_stall),
    .data_byte  (data_byte),
    .is_final   (is_final),
    .advance    (out_ready),
    .item_valid (item_valid),
    .item       (item)
  );

  assign step = item_valid && out_ready;

  efc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  efc_out_reg u_out_reg (
    .clk           (clk),
    .rst           (rst),
    .load          (step),
    .result        (result),
    .ready         (out_ready),
    .result_valid  (result_valid),
    .result_stall  (result_stall),
    .payload_byte  (payload_byte),
    .payload_valid (payload_valid),
    .frame_done    (frame_done),
    .frame_status  (frame_status),
    .version_seen  (version_seen)
  );

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    data_stall |-> item_valid && result_valid)
    else $error("input stalled while a pipeline stage is free");

  a_status_only_on_final: assert property (@(posedge clk) disable iff (rst)
    result_valid && !frame_done |-> frame_status == ST_OK && version_seen == 32'd0)
    else $error("status or version reported on a byte that is not final");

  a_version_only_when_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && frame_status != ST_OK |-> version_seen == 32'd0)
    else $error("version reported on a failed frame");

  a_step_fills_result: assert property (@(posedge clk) disable iff (rst)
    step |=> result_valid)
    else $error("processed byte did not reach the result register");

endmodule

// File: rtl/efc_in_reg.sv
`timescale 1ns / 1ps
// Input register stage: holds one accepted byte until the result stage can take it.
// Depends on efc_pkg.
module efc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              data_valid,
  output logic              data_stall,
  input  logic [7:0]        data_byte,
  input  logic              is_final,
  input  logic              advance,
  output logic              item_valid,
  output efc_pkg::in_item_t item
);
  import efc_pkg::*;

  logic load;

  assign data_stall = item_valid && !advance;
  assign load = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (load) begin
      item_valid <= data_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load && data_valid) begin
      item.data_byte <= data_byte;
      item.is_final <= is_final;
    end
  end

endmodule

// File: rtl/efc_core.sv
`timescale 1ns / 1ps
// Frame state and the per-byte header, payload, trailer and status logic.
// Depends on efc_pkg for types, constants and the CRC function.
module efc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  efc_pkg::in_item_t item,
  input  efc_pkg::cfg_t     cfg,
  output efc_pkg::result_t  result
);
  import efc_pkg::*;

  count_t      byte_count, byte_count_next;
  count_t      pay_end, pay_end_next;
  count_t      trail_end, trail_end_next;
  logic [31:0] header_shift, header_shift_next;
  logic [31:0] version_reg, version_reg_next;
  logic [31:0] crc_accum, crc_accum_next;
  logic [31:0] trailer_word, trailer_word_next;
  status_t     error_code, error_code_next;

  always_comb begin
    header_shift_next = header_shift;
    version_reg_next = version_reg;
    crc_accum_next = crc_accum;
    trailer_word_next = trailer_word;
    error_code_next = error_code;
    pay_end_next = pay_end;
    trail_end_next = trail_end;
    result = '0;
    result.frame_status = ST_OK;

    if (byte_count < HDR_BYTES) begin
      header_shift_next = {item.data_byte, header_shift[31:8]};
      if (byte_count == POS_MAGIC) begin
        if (header_shift_next != cfg.magic) begin
          error_code_next = ST_MAGIC;
        end
      end else if (byte_count == POS_VERSION) begin
        version_reg_next = header_shift_next;
        if (error_code == ST_OK &&
            (header_shift_next < cfg.ver_min || header_shift_next > cfg.ver_max)) begin
          error_code_next = ST_VERSION;
        end
      end else if (byte_count == POS_LENGTH) begin
        pay_end_next = HDR_BYTES + count_t'(header_shift_next);
        trail_end_next = HDR_BYTES + TRAILER_BYTES + count_t'(header_shift_next);
      end
    end else if (byte_count < pay_end) begin
      if (error_code == ST_OK) begin
        result.payload_valid = 1'b1;
        result.payload_byte = item.data_byte;
        crc_accum_next = crc_byte(crc_accum, item.data_byte);
      end
    end else if (byte_count < trail_end) begin
      trailer_word_next = {item.data_byte, trailer_word[31:8]};
    end else if (!item.is_final && error_code == ST_OK) begin
      error_code_next = ST_SIZE;
    end

    byte_count_next = (byte_count != COUNT_MAX) ? byte_count + count_t'(1) : byte_count;

    if (item.is_final) begin
      result.frame_done = 1'b1;
      priority if (byte_count_next < HDR_BYTES) begin
        result.frame_status = ST_TRUNC;
      end else if (error_code_next != ST_OK) begin
        result.frame_status = error_code_next;
      end else if (byte_count_next != trail_end) begin
        result.frame_status = ST_SIZE;
      end else if (trailer_word_next != (crc_accum_next ^ CRC_XOROUT)) begin
        result.frame_status = ST_CRC;
      end else begin
        result.frame_status = ST_OK;
        result.version_seen = version_reg_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || (step && item.is_final)) begin
      byte_count <= '0;
      pay_end <= HDR_BYTES;
      trail_end <= HDR_BYTES + TRAILER_BYTES;
      header_shift <= '0;
      version_reg <= '0;
      crc_accum <= CRC_INIT;
      trailer_word <= '0;
      error_code <= ST_OK;
    end else if (step) begin
      byte_count <= byte_count_next;
      pay_end <= pay_end_next;
      trail_end <= trail_end_next;
      header_shift <= header_shift_next;
      version_reg <= version_reg_next;
      crc_accum <= crc_accum_next;
      trailer_word <= trailer_word_next;
      error_code <= error_code_next;
    end
  end

endmodule

// File: rtl/efc_out_reg.sv
`timescale 1ns / 1ps
// Result register: holds one result until the downstream transfer completes.
// Depends on efc_pkg for the result type.
module efc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  efc_pkg::result_t result,
  output logic             ready,
  output logic             result_valid,
  input  logic             result_stall,
  output logic [7:0]       payload_byte,
  output logic             payload_valid,
  output logic             frame_done,
  output logic [2:0]       frame_status,
  output logic [31:0]      version_seen
);
  import efc_pkg::*;

  result_t held;

  assign ready = !result_valid || !result_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (ready) begin
      result_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (ready && load) begin
      held <= result;
    end
  end

  assign payload_byte = held.payload_byte;
  assign payload_valid = held.payload_valid;
  assign frame_done = held.frame_done;
  assign frame_status = held.frame_status;
  assign version_seen = held.version_seen;

endmodule

// File: sim/efc_frame_monitor.sv
`timescale 1ns / 1ps
// Frame monitor for the envelope frame checker: follows every transfer on the data, result
// and register channels, predicts each result on its own and compares it field by field.
// Depends on efc_pkg for the result and status types and the header and CRC constants.
module efc_frame_monitor (
  input  logic        clk,
  input  logic        rst,
  input  logic        data_valid,
  input  logic        data_stall,
  input  logic [7:0]  data_byte,
  input  logic        is_final,
  input  logic        result_valid,
  input  logic        result_stall,
  input  logic [7:0]  payload_byte,
  input  logic        payload_valid,
  input  logic        frame_done,
  input  logic [2:0]  frame_status,
  input  logic [31:0] version_seen,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          failures,
  output int          outstanding
);
  import efc_pkg::*;

  logic [31:0] magic_reg;
  logic [31:0] vmin_reg;
  logic [31:0] vmax_reg;
  count_t      seen_count;
  logic [31:0] hdr_shift;
  logic [31:0] pay_len;
  logic [31:0] ver_word;
  logic [31:0] crc_run;
  logic [31:0] trailer_shift;
  status_t     latched_err;
  result_t     byte_results[$];

  initial begin
    failures = 0;
    outstanding = 0;
  end

  function automatic logic [31:0] crc32_feed(input logic [31:0] crc, input logic [7:0] octet);
    logic [31:0] c;
    c = crc;
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0] ^ octet[k]}});
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (failures < 100) begin
      $display("%0t: %s: got %0h, want %0h", $time, what, got, want);
    end
    failures++;
  endtask

  task automatic reset_frame_state();
    seen_count = '0;
    hdr_shift = '0;
    pay_len = '0;
    ver_word = '0;
    crc_run = CRC_INIT;
    trailer_shift = '0;
    latched_err = ST_OK;
  endtask

  task automatic step_envelope(input logic [7:0] octet, input logic fin);
    result_t     r;
    logic [34:0] pay_end;
    r = '0;
    pay_end = 35'(HDR_BYTES) + 35'(pay_len);
    if (seen_count < HDR_BYTES) begin
      hdr_shift = {octet, hdr_shift[31:8]};
      if (seen_count == POS_MAGIC) begin
        if (hdr_shift != magic_reg) latched_err = ST_MAGIC;
      end else if (seen_count == POS_VERSION) begin
        ver_word = hdr_shift;
        if (latched_err == ST_OK && (ver_word < vmin_reg || ver_word > vmax_reg)) begin
          latched_err = ST_VERSION;
        end
      end else if (seen_count == POS_LENGTH) begin
        pay_len = hdr_shift;
      end
    end else if (35'(seen_count) < pay_end) begin
      if (latched_err == ST_OK) begin
        r.payload_valid = 1'b1;
        r.payload_byte = octet;
        crc_run = crc32_feed(crc_run, octet);
      end
    end else if (35'(seen_count) < pay_end + 35'(TRAILER_BYTES)) begin
      trailer_shift = {octet, trailer_shift[31:8]};
    end else if (!fin && latched_err == ST_OK) begin
      latched_err = ST_SIZE;
    end

    if (seen_count != COUNT_MAX) seen_count = seen_count + count_t'(1);

    if (fin) begin
      r.frame_done = 1'b1;
      if (seen_count < HDR_BYTES) begin
        r.frame_status = ST_TRUNC;
      end else if (latched_err != ST_OK) begin
        r.frame_status = latched_err;
      end else if (35'(seen_count) != pay_end + 35'(TRAILER_BYTES)) begin
        r.frame_status = ST_SIZE;
      end else if (trailer_shift != (crc_run ^ CRC_XOROUT)) begin
        r.frame_status = ST_CRC;
      end else begin
        r.frame_status = ST_OK;
        r.version_seen = ver_word;
      end
      reset_frame_state();
    end
    byte_results = {byte_results, r};
  endtask

  task automatic check_result();
    result_t want;
    if (byte_results.size() == 0) begin
      report_mismatch("result transfer with nothing pending", 32'd0, 32'd0);
      return;
    end
    want = byte_results.pop_front();
    if (payload_valid !== want.payload_valid) begin
      report_mismatch("payload_valid", 32'(payload_valid), 32'(want.payload_valid));
    end
    if (payload_byte !== want.payload_byte) begin
      report_mismatch("payload_byte", 32'(payload_byte), 32'(want.payload_byte));
    end
    if (frame_done !== want.frame_done) begin
      report_mismatch("frame_done", 32'(frame_done), 32'(want.frame_done));
    end
    if (frame_status !== want.frame_status) begin
      report_mismatch("frame_status", 32'(frame_status), 32'(want.frame_status));
    end
    if (version_seen !== want.version_seen) begin
      report_mismatch("version_seen", version_seen, want.version_seen);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      magic_reg = MAGIC_RESET;
      vmin_reg = VER_MIN_RESET;
      vmax_reg = VER_MAX_RESET;
      reset_frame_state();
      byte_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAGIC: magic_reg = cfg_data;
          REG_VER_MIN: vmin_reg = cfg_data;
          REG_VER_MAX: vmax_reg = cfg_data;
          default: ;
        endcase
      end
      if (result_valid && !result_stall) check_result();
      if (data_valid && !data_stall) step_envelope(data_byte, is_final);
    end
    outstanding = byte_results.size();
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
// Top of the envelope frame checker testbench: clock, reset, register writes, envelope
// stimulus and the verdict. Depends on efc_pkg, envelope_frame_checker and efc_frame_monitor.
module tb;
  import efc_pkg::*;

  localparam int CycleLimit = 1_000_000;
  localparam logic [1:0] RegUnused = 2'd3;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        data_valid = 1'b0;
  logic        data_stall;
  logic [7:0]  data_byte = 8'd0;
  logic        is_final = 1'b0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [7:0]  payload_byte;
  logic        payload_valid;
  logic        frame_done;
  logic [2:0]  frame_status;
  logic [31:0] version_seen;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  int          failures;
  int          outstanding;
  int          cycle_count = 0;
  int          sent_bytes = 0;
  logic        steady = 1'b0;
  logic [31:0] cur_magic = MAGIC_RESET;
  logic [31:0] cur_min = VER_MIN_RESET;
  logic [31:0] cur_max = VER_MAX_RESET;
  logic [7:0]  env_bytes[$];

  envelope_frame_checker u_top (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .is_final     (is_final),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .payload_byte (payload_byte),
    .payload_valid(payload_valid),
    .frame_done   (frame_done),
    .frame_status (frame_status),
    .version_seen (version_seen),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  efc_frame_monitor u_monitor (
    .clk          (clk),
    .rst          (rst),
    .data_valid   (data_valid),
    .data_stall   (data_stall),
    .data_byte    (data_byte),
    .is_final     (is_final),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .payload_byte (payload_byte),
    .payload_valid(payload_valid),
    .frame_done   (frame_done),
    .frame_status (frame_status),
    .version_seen (version_seen),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .failures     (failures),
    .outstanding  (outstanding)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic int idle_length();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 80);
  endfunction

  initial begin
    int run;
    int hold;
    forever begin
      run = steady ? 50 : (($urandom_range(0, 3) == 0) ? $urandom_range(20, 80)
                                                       : $urandom_range(1, 4));
      result_stall <= 1'b0;
      repeat (run) @(posedge clk);
      hold = idle_length();
      if (hold > 0) begin
        result_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
    end
  end

  function automatic logic [31:0] good_version();
    logic [63:0] span;
    if (cur_min > cur_max) return $urandom();
    case ($urandom_range(0, 3))
      0: return cur_min;
      1: return cur_max;
      default: begin
        span = 64'(cur_max) - 64'(cur_min) + 64'd1;
        return cur_min + 32'({$urandom(), $urandom()} % span);
      end
    endcase
  endfunction

  function automatic logic [31:0] bad_version();
    if (cur_min != 32'd0 && (cur_max == '1 || $urandom_range(0, 1) == 1)) begin
      return ($urandom_range(0, 1) == 1) ? cur_min - 32'd1 : $urandom() % cur_min;
    end
    if (cur_max != '1) begin
      return ($urandom_range(0, 1) == 1) ? cur_max + 32'd1
                                         : cur_max + 32'd1 + $urandom() % (~cur_max);
    end
    return $urandom();
  endfunction

  task automatic wait_drained();
    data_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic settle();
    wait_drained();
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    logic taken;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = cfg_ready;
      @(posedge clk);
    end
    cfg_valid <= 1'b0;
    case (idx)
      REG_MAGIC: cur_magic = val;
      REG_VER_MIN: cur_min = val;
      REG_VER_MAX: cur_max = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic send_byte(input logic [7:0] octet, input logic fin);
    int   gap;
    logic taken;
    gap = idle_length();
    if (!steady && $urandom_range(0, 199) == 0) begin
      wait_drained();
    end else if (gap > 0) begin
      data_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    data_valid <= 1'b1;
    data_byte <= octet;
    is_final <= fin;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !data_stall;
      @(posedge clk);
    end
    sent_bytes++;
  endtask

  task automatic send_envelope();
    for (int k = 0; k < env_bytes.size(); k++) begin
      send_byte(env_bytes[k], k == env_bytes.size() - 1);
    end
  endtask

  task automatic push_word(input logic [31:0] w);
    for (int k = 0; k < 4; k++) begin
      env_bytes = {env_bytes, w[8*k +: 8]};
    end
  endtask

  task automatic build_frame(input logic [31:0] magic_w, input logic [31:0] ver_w,
                             input logic [31:0] len_w, input int npay);
    logic [31:0] crc;
    logic [7:0]  octet;
    env_bytes.delete();
    push_word(magic_w);
    push_word(ver_w);
    push_word(len_w);
    crc = CRC_INIT;
    repeat (npay) begin
      octet = 8'($urandom());
      env_bytes = {env_bytes, octet};
      crc = crc_byte(crc, octet);
    end
    push_word(crc ^ CRC_XOROUT);
  endtask

  task automatic send_random_frame();
    int          kind;
    int          npay;
    int          cut;
    int          idx;
    logic [31:0] magic_w;
    logic [31:0] ver_w;
    logic [31:0] len_w;
    kind = $urandom_range(0, 99);
    magic_w = cur_magic;
    ver_w = good_version();
    npay = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 64) : $urandom_range(0, 24);
    len_w = 32'(npay);
    if (kind >= 97) begin
      env_bytes.delete();
      repeat ($urandom_range(1, 30)) env_bytes = {env_bytes, 8'($urandom())};
    end else begin
      if ((kind >= 55 && kind < 61) || kind == 96) magic_w = magic_w ^ ($urandom() | 32'd1);
      if ((kind >= 61 && kind < 67) || kind == 96) ver_w = bad_version();
      if (kind >= 67 && kind < 70) begin
        len_w = 32'hFFFF_FFFF - 32'($urandom_range(0, 3));
        npay = $urandom_range(0, 20);
      end
      build_frame(magic_w, ver_w, len_w, npay);
      if (kind >= 70 && kind < 76) begin
        idx = $urandom_range(12, env_bytes.size() - 1);
        env_bytes[idx] = env_bytes[idx] ^ 8'(1 << $urandom_range(0, 7));
      end
      if (kind >= 76 && kind < 83) cut = $urandom_range(12, env_bytes.size() - 1);
      else if (kind >= 83 && kind < 88) cut = $urandom_range(1, 11);
      else cut = env_bytes.size();
      while (env_bytes.size() > cut) void'(env_bytes.pop_back());
      if (kind >= 88 && kind < 95) begin
        repeat ($urandom_range(1, 6)) env_bytes = {env_bytes, 8'($urandom())};
      end
    end
    send_envelope();
  endtask

  task automatic run_phase(input int budget);
    int goal;
    goal = sent_bytes + budget;
    while (sent_bytes < goal) begin
      if ($urandom_range(0, 14) == 0) wait_drained();
      send_random_frame();
    end
    settle();
  endtask

  initial begin
    logic [31:0] lo;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    env_bytes.delete();
    env_bytes = {env_bytes, 8'hFF};
    send_envelope();
    build_frame(cur_magic, cur_max, 32'd1, 1);
    send_envelope();
    env_bytes.delete();
    repeat (6) env_bytes = {env_bytes, 8'h00};
    send_envelope();
    settle();

    write_reg(REG_MAGIC, $urandom());
    write_reg(REG_VER_MIN, 32'd0);
    write_reg(REG_VER_MAX, 32'hFFFF_FFFF);
    run_phase(320);

    write_reg(REG_MAGIC, 32'd0);
    write_reg(REG_VER_MIN, 32'hFFFF_FFFF);
    write_reg(REG_VER_MAX, 32'hFFFF_FFFF);
    run_phase(320);

    write_reg(REG_MAGIC, 32'hFFFF_FFFF);
    write_reg(REG_VER_MIN, 32'd5);
    write_reg(REG_VER_MAX, 32'd3);
    write_reg(RegUnused, $urandom());
    run_phase(280);

    lo = $urandom();
    write_reg(REG_MAGIC, $urandom());
    write_reg(REG_VER_MIN, lo);
    write_reg(REG_VER_MAX, lo + 32'($urandom_range(0, 3)));
    run_phase(320);

    write_reg(REG_MAGIC, MAGIC_RESET);
    write_reg(REG_VER_MIN, VER_MIN_RESET);
    write_reg(REG_VER_MAX, VER_MAX_RESET);
    steady = 1'b1;
    run_phase(280);
    steady = 1'b0;
    run_phase(300);

    @(negedge clk);
    if (failures == 0 && outstanding == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
